### design/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg: shared types, constants and round helpers
// Queue item type, sequencer states, SHA-1 initial values and round functions.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_MARK = 32'h80000000;
  localparam logic [2:0]  FULL_WORD = 3'd4;

  // one classified input item as it sits in the queue
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } core_state_t;

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = K0;
    end else if (r < 7'd40) begin
      k = K1;
    end else if (r < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  // final data word: keep the valid leading bytes, place the 0x80 marker after them unless all four are valid
  function automatic logic [31:0] tail_word(input logic [31:0] w, input logic [2:0] v);
    logic [31:0] r;
    case (v)
      3'd0:    r = 32'h80000000;
      3'd1:    r = {w[31:24], 24'h800000};
      3'd2:    r = {w[31:16], 16'h8000};
      3'd3:    r = {w[31:8], 8'h80};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

### design/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front: input side
// Accepts message words and classifies them into queue items: inner words
// always count four bytes, the final word's byte count saturates at four.
// ----------------------------------------------------------------------------
module sha1_front
  import sha1_pkg::*;
(
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // message_word
  input  logic [2:0]  s_tuser,   // valid_bytes
  input  logic        s_tlast,   // last_word
  input  logic        q_full,
  output logic        q_push,
  output q_item_t     q_item
);

  logic [2:0] nbytes;

  always_comb begin
    if (!s_tlast || s_tuser > FULL_WORD) begin
      nbytes = FULL_WORD;
    end else begin
      nbytes = s_tuser;
    end
  end

  assign s_tready      = !q_full;
  assign q_push        = s_tvalid && !q_full;
  assign q_item.word   = s_tdata;
  assign q_item.nbytes = nbytes;
  assign q_item.last   = s_tlast;

endmodule

### design/sha1_queue.sv
// ----------------------------------------------------------------------------
// sha1_queue: item queue
// Short FIFO between the input side and the compression sequencer.
// ----------------------------------------------------------------------------
module sha1_queue
  import sha1_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output q_item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t        mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/sha1_core.sv
// ----------------------------------------------------------------------------
// sha1_core: compression sequencer
// Loads the 16-word schedule line, generates padding words, runs one SHA-1
// round per cycle, folds into the chaining words and registers the digest.
// ----------------------------------------------------------------------------
module sha1_core
  import sha1_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  q_item_t        q_head,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [159:0]   m_tdata
);

  core_state_t state, state_next;

  logic [31:0] w [16];          // schedule line, w[0] is the current round word
  logic [31:0] a, b, c, d, e;
  logic [31:0] h0, h1, h2, h3, h4;
  logic [6:0]  round;
  logic [3:0]  wcnt;
  logic [63:0] byte_cnt;
  logic [4:0]  pos;             // position within the padded tail, 0..31
  logic [3:0]  tail_n;
  logic [31:0] tail_w;
  logic [2:0]  tail_v;
  logic        two_blk;
  logic        in_pad;

  logic [31:0] pad_w;
  logic [31:0] w_new;
  logic [31:0] t_sum;
  logic [63:0] bit_len;
  logic [6:0]  used;
  logic        shift_in;
  logic [31:0] shift_word;
  logic        load_out;

  assign bit_len = {byte_cnt[60:0], 3'b000};
  assign used    = {1'b0, wcnt, 2'b00} + {4'd0, q_head.nbytes} + 7'd1;

  // padding word for tail position pos
  always_comb begin
    pad_w = '0;
    if (pos == {1'b0, tail_n}) begin
      pad_w = tail_word(tail_w, tail_v);
    end else if (tail_v == FULL_WORD && pos == {1'b0, tail_n} + 5'd1) begin
      pad_w = PAD_MARK;
    end else if (pos == {two_blk, 4'd14}) begin
      pad_w = bit_len[63:32];
    end else if (pos == {two_blk, 4'd15}) begin
      pad_w = bit_len[31:0];
    end
  end

  assign w_new = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                  w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};
  assign t_sum = {a[26:0], a[31:27]} + round_f(round, b, c, d) + e + round_k(round) + w[0];

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    shift_in   = 1'b0;
    shift_word = pad_w;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          if (!q_head.last) begin
            shift_in   = 1'b1;
            shift_word = q_head.word;
            if (wcnt == 4'd15) begin
              state_next = ST_ROUND;
            end
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_in = 1'b1;
        if (pos[3:0] == 4'd15) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round == 7'd79) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!in_pad) begin
          state_next = ST_IDLE;
        end else if (two_blk && pos == 5'd16) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // schedule line and working variables
  always_ff @(posedge clk) begin
    if (shift_in) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= shift_word;
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
    if (state_next == ST_ROUND && state != ST_ROUND) begin
      a <= h0;
      b <= h1;
      c <= h2;
      d <= h3;
      e <= h4;
    end else if (state == ST_ROUND) begin
      a <= t_sum;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
    if (state == ST_IDLE && q_valid && q_head.last) begin
      tail_w  <= q_head.word;
      tail_v  <= q_head.nbytes;
      tail_n  <= wcnt;
      two_blk <= (used > 7'd56);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h0       <= IV0;
      h1       <= IV1;
      h2       <= IV2;
      h3       <= IV3;
      h4       <= IV4;
      round    <= '0;
      wcnt     <= '0;
      byte_cnt <= '0;
      pos      <= '0;
      in_pad   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          round <= '0;
          if (q_valid) begin
            if (!q_head.last) begin
              wcnt     <= wcnt + 4'd1;
              byte_cnt <= byte_cnt + 64'd4;
            end else begin
              byte_cnt <= byte_cnt + {61'd0, q_head.nbytes};
              pos      <= {1'b0, wcnt};
              wcnt     <= '0;
              in_pad   <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          pos <= pos + 5'd1;
        end
        ST_ROUND: begin
          round <= round + 7'd1;
        end
        ST_FINAL: begin
          round <= '0;
          h0    <= h0 + a;
          h1    <= h1 + b;
          h2    <= h2 + c;
          h3    <= h3 + d;
          h4    <= h4 + e;
        end
        ST_OUT: begin
          if (load_out) begin
            h0       <= IV0;
            h1       <= IV1;
            h2       <= IV2;
            h3       <= IV3;
            h4       <= IV4;
            byte_cnt <= '0;
            in_pad   <= 1'b0;
          end
        end
        default: ;
      endcase
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {h4, h3, h2, h1, h0};
    end
  end

endmodule

### design/sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine: streaming SHA-1 engine
// Hashes a stream of big-endian words with hardware padding, one digest per
// message.
// ----------------------------------------------------------------------------
// Message words enter on the s_ side, first byte in bits 31..24; the word with
// s_tlast set ends the message and s_tuser gives its valid leading bytes (0 to
// 4). A short queue takes words while the sequencer works. Each 16-word block
// loads the schedule line from the queue, runs the SHA-1 rounds on the single
// round datapath and folds into the chaining words. After the last word the
// sequencer generates the pad words of the first padded block and compresses
// it, does the same for a second block when one is needed, then registers the
// 160-bit digest, h0 in the low 32 bits, once the output is free. The engine
// then starts over from the initial chaining values.
module sha1_hash_engine
  import sha1_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // message_word
  input  logic [2:0]   s_tuser,   // valid_bytes
  input  logic         s_tlast,   // last_word
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata    // digest_h0, digest_h1, digest_h2, digest_h3, digest_h4
);

  q_item_t in_item;
  q_item_t head;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;

  sha1_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (in_item)
  );

  sha1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head)
  );

  sha1_core u_core (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sha1_hash_engine
// Streams messages as big-endian words, both directed (empty message, short
// strings, block-boundary and byte-count corner cases) and random, some with
// lengths aimed at the one/two pad-block split. A behavioral SHA-1 model
// predicts each digest not typed in, and every digest item is checked word by word.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [4:0][31:0]  digest_t;   // [0] = h0
  typedef logic [15:0][31:0] block_t;    // [0] = first word of the block

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic        known;    // digest typed in below, not taken from the model
    digest_t     digest;
  } stim_row_t;

  localparam digest_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};
  localparam logic [31:0] RK0 = 32'h5A827999;
  localparam logic [31:0] RK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RK3 = 32'hCA62C1D6;
  localparam logic [31:0] PAD_BYTE_MSB = 32'h80000000;
  localparam int          MSG_ITEMS = 1450;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [31:0]  s_tdata;    // message_word
  logic [2:0]   s_tuser;    // valid_bytes
  logic         s_tlast;    // last_word
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;    // digest_h0, digest_h1, digest_h2, digest_h3, digest_h4

  // typed expectation travels with the item on the bus
  logic         row_known;
  digest_t      row_digest;

  // hash model state
  digest_t      chain_h = SHA1_IV;
  block_t       blk_words = '0;
  int           blk_fill = 0;
  logic [63:0]  msg_bytes = '0;

  digest_t      pending_digests[$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           burst_left = 0;
  int           ready_mode = 0;
  int           ready_left = 0;

  sha1_hash_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void sha1_compress(input block_t blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) w[r] = blk[r];
    for (int r = 16; r < 80; r++) begin
      t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {t[30:0], t[31]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK2;
      end else begin
        f = b ^ c ^ d;
        k = RK3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // one accepted word; on the last word pads, finishes and restarts the hash
  function automatic void sha1_absorb(input logic [31:0] word, input logic [2:0] nb,
                                      input logic last, output digest_t dg,
                                      output logic done);
    logic [31:0][31:0] tail;
    logic [31:0]       keep;
    logic [63:0]       bits;
    logic [2:0]        v;
    logic              two;
    int                n;
    dg = '0;
    done = 1'b0;
    if (!last) begin
      // byte count field is ignored here, always four bytes
      blk_words[blk_fill] = word;
      blk_fill++;
      msg_bytes += 64'd4;
      if (blk_fill == 16) begin
        sha1_compress(blk_words);
        blk_fill = 0;
      end
    end else begin
      v = (nb > 3'd4) ? 3'd4 : nb;
      msg_bytes += {61'd0, v};
      n = blk_fill;
      tail = '0;
      for (int i = 0; i < n; i++) tail[i] = blk_words[i];
      if (v == 3'd4) begin
        tail[n] = word;
        tail[n+1] = PAD_BYTE_MSB;
      end else begin
        keep = (v == 3'd0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * v));
        tail[n] = (word & keep) | (PAD_BYTE_MSB >> (8 * v));
      end
      two = (4 * n + v + 1) > 56;
      bits = msg_bytes << 3;
      if (two) begin
        tail[30] = bits[63:32];
        tail[31] = bits[31:0];
      end else begin
        tail[14] = bits[63:32];
        tail[15] = bits[31:0];
      end
      sha1_compress(tail[15:0]);
      if (two) sha1_compress(tail[31:16]);
      dg = chain_h;
      done = 1'b1;
      chain_h = SHA1_IV;
      blk_fill = 0;
      msg_bytes = '0;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    digest_t got;
    digest_t want;
    digest_t calc;
    logic    produced;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_digests.size() == 0) begin
          if (mismatches < 10) $display("unexpected digest item %h", got);
          mismatches++;
        end else begin
          want = pending_digests.pop_front();
          for (int f = 0; f < 5; f++) begin
            if (got[f] !== want[f]) begin
              if (mismatches < 10)
                $display("digest_h%0d mismatch: expected %08h, got %08h",
                         f, want[f], got[f]);
              mismatches++;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        sha1_absorb(s_tdata, s_tuser, s_tlast, calc, produced);
        if (produced) pending_digests.push_back(row_known ? row_digest : calc);
      end
    end
  end

  // receiver: alternating stretches of always ready, coin flip, mostly stalled
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(4, 60);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [31:0] word, input logic [2:0] nb,
                           input logic last, input logic known, input digest_t dg);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid   <= 1'b1;
    s_tdata    <= word;
    s_tuser    <= nb;
    s_tlast    <= last;
    row_known  <= known;
    row_digest <= dg;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h00000000;
      1:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    stim_row_t   dir_rows[$];
    logic [31:0] word;
    logic [2:0]  nb;
    int          len;
    int          pick;
    int          msg_num;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    s_tlast    = 1'b0;
    row_known  = 1'b0;
    row_digest = '0;
    rst        = 1'b1;

    // empty message, bytes of the word must be dropped
    dir_rows.push_back('{32'hFFFFFFFF, 3'd0, 1'b1, 1'b1,
                         {32'hafd80709, 32'h95601890, 32'h3255bfef, 32'h5e6b4b0d,
                          32'hda39a3ee}});
    // "a"
    dir_rows.push_back('{32'h61FFFFFF, 3'd1, 1'b1, 1'b1,
                         {32'h377667b8, 32'hb9eaeaea, 32'he15d1ddc, 32'hfaa5a7fc,
                          32'h86f7e437}});
    // "abc"
    dir_rows.push_back('{32'h61626364, 3'd3, 1'b1, 1'b1,
                         {32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571, 32'h4706816a,
                          32'ha9993e36}});
    // byte count above four saturates
    dir_rows.push_back('{32'hFFFFFFFF, 3'd7, 1'b1, 1'b0, '0});
    dir_rows.push_back('{32'h00000000, 3'd5, 1'b1, 1'b0, '0});
    // one full block with junk byte counts on inner words, then a short tail
    for (int i = 0; i < 16; i++)
      dir_rows.push_back('{(i % 2) ? 32'hFFFFFFFF : 32'h00000000, 3'(i % 8), 1'b0,
                           1'b0, '0});
    dir_rows.push_back('{32'h80000000, 3'd6, 1'b1, 1'b0, '0});
    dir_rows.push_back('{32'h01234567, 3'd4, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'h89ABCDEF, 3'd0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'hFEDCBA98, 3'd2, 1'b1, 1'b0, '0});

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r])
      send_word(dir_rows[r].word, dir_rows[r].nbytes, dir_rows[r].last,
                dir_rows[r].known, dir_rows[r].digest);
    drain_results();

    msg_num = 0;
    while (items_sent < MSG_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        len = 0;
      end else if (pick < 4) begin
        // tails near the one/two pad-block split, incl. whole blocks
        len = 16 * $urandom_range(0, 2) + $urandom_range(12, 16);
      end else if (pick == 4) begin
        len = $urandom_range(41, 80);
      end else begin
        len = $urandom_range(1, 40);
      end
      for (int i = 0; i < len; i++) begin
        word = pick_word();
        nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
        send_word(word, nb, 1'b0, 1'b0, '0);
      end
      word = pick_word();
      send_word(word, 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
      msg_num++;
      if (msg_num == 25) drain_results();
    end

    s_tvalid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
design/sha1_pkg.sv
design/sha1_front.sv
design/sha1_queue.sv
design/sha1_core.sv
design/sha1_hash_engine.sv
tb/sv/testbench.sv
